// ===== rtl/core/erc_pkg.sv =====
// Shared types and constants of the Euler rigid transform block.
// Depends on nothing; the RTL files refer to it by scoped names and the testbench imports it.
`default_nettype none

package erc_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int TRIG_FRAC_DEF   = 14;
   localparam int PORT_WIDTH      = 32;
   localparam int TRIG_WIDTH      = 16;
   localparam int CSR_INDEX_WIDTH = 3;

   // Input register with clip, inverse translation, three rotations of two
   // stages each, forward translation.
   localparam int LATENCY = 9;

   localparam logic [PORT_WIDTH-1:0] SHIFT_RESET = 32'h0000_0000;
   localparam logic [PORT_WIDTH-1:0] TRIG_RESET  = 32'h4000_0000;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_SHIFT_X = 3'd0,
      REG_SHIFT_Y = 3'd1,
      REG_SHIFT_Z = 3'd2,
      REG_YAW     = 3'd3,
      REG_PITCH   = 3'd4,
      REG_ROLL    = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   // A rotation acts on the pair (a, b): a' = a*c - b*s, b' = a*s + b*c.
   typedef struct packed {
      axis_type a;
      axis_type b;
   } plane_type;

   typedef struct packed {
      logic valid;
      logic inverse;
      logic clipped;
   } ctl_type;

   typedef struct packed {
      logic                         func;
      logic signed [PORT_WIDTH-1:0] point_x;
      logic signed [PORT_WIDTH-1:0] point_y;
      logic signed [PORT_WIDTH-1:0] point_z;
   } req_type;

   typedef struct packed {
      logic signed [PORT_WIDTH-1:0] result_x;
      logic signed [PORT_WIDTH-1:0] result_y;
      logic signed [PORT_WIDTH-1:0] result_z;
      logic                         saturated;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/core/erc_xlate.sv =====
// Translation stage: adds or subtracts the shift vector with saturation for items of its
// direction and passes the others through, one register stage. Depends on erc_pkg.
`default_nettype none

module erc_xlate #(
   parameter int COORD_WIDTH = erc_pkg::COORD_WIDTH_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 on_inverse,
   input  wire erc_pkg::ctl_type                     src_ctl,
   input  wire logic signed [COORD_WIDTH-1:0]        src_point [3],
   input  wire logic signed [erc_pkg::PORT_WIDTH-1:0] shift [3],
   output erc_pkg::ctl_type                          dst_ctl,
   output logic signed [COORD_WIDTH-1:0]             dst_point [3]
);

   localparam int BW = ((COORD_WIDTH > erc_pkg::PORT_WIDTH) ? COORD_WIDTH
                                                             : erc_pkg::PORT_WIDTH) + 1;
   localparam logic signed [BW-1:0] SAT_HI = BW'({1'b0, {(COORD_WIDTH-1){1'b1}}});
   localparam logic signed [BW-1:0] SAT_LO = -SAT_HI - BW'(1);

   function automatic logic [COORD_WIDTH:0] clip(input logic signed [BW-1:0] v);
      if (v > SAT_HI) begin
         clip = {1'b1, SAT_HI[COORD_WIDTH-1:0]};
      end else if (v < SAT_LO) begin
         clip = {1'b1, SAT_LO[COORD_WIDTH-1:0]};
      end else begin
         clip = {1'b0, v[COORD_WIDTH-1:0]};
      end
   endfunction

   erc_pkg::ctl_type              ctl_ff, ctl_in;
   logic signed [COORD_WIDTH-1:0] point_ff [3];
   logic signed [COORD_WIDTH-1:0] point_in [3];
   logic signed [BW-1:0]          sum [3];
   logic [COORD_WIDTH:0]          clipped [3];
   logic                          apply;

   always_comb begin
      // The stage only acts on items whose direction matches it.
      apply  = (src_ctl.inverse == on_inverse);
      ctl_in = src_ctl;
      for (int i = 0; i < 3; i++) begin
         if (on_inverse) begin
            sum[i] = BW'(src_point[i]) - BW'(shift[i]);
         end else begin
            sum[i] = BW'(src_point[i]) + BW'(shift[i]);
         end
         clipped[i] = clip(sum[i]);
         if (apply) begin
            point_in[i]    = clipped[i][COORD_WIDTH-1:0];
            ctl_in.clipped = ctl_in.clipped | clipped[i][COORD_WIDTH];
         end else begin
            point_in[i] = src_point[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         point_ff[i] <= point_in[i];
      end
   end

   assign dst_ctl = ctl_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dst_point[i] = point_ff[i];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/erc_rot.sv =====
// Plane rotation unit: four products in the first stage, add and saturate in the second.
// Depends on erc_pkg.
`default_nettype none

module erc_rot #(
   parameter int COORD_WIDTH = erc_pkg::COORD_WIDTH_DEF,
   parameter int TRIG_FRAC   = erc_pkg::TRIG_FRAC_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire erc_pkg::plane_type              fwd_plane,
   input  wire erc_pkg::plane_type              inv_plane,
   input  wire logic [erc_pkg::PORT_WIDTH-1:0]  fwd_trig,
   input  wire logic [erc_pkg::PORT_WIDTH-1:0]  inv_trig,
   input  wire erc_pkg::ctl_type                src_ctl,
   input  wire logic signed [COORD_WIDTH-1:0]   src_point [3],
   output erc_pkg::ctl_type                     dst_ctl,
   output logic signed [COORD_WIDTH-1:0]        dst_point [3]
);

   localparam int TW = erc_pkg::TRIG_WIDTH;
   localparam int PW = COORD_WIDTH + TW;
   localparam int SW = PW + 1;
   localparam logic signed [SW-1:0] SAT_HI = SW'({1'b0, {(COORD_WIDTH-1){1'b1}}});
   localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

   function automatic logic [COORD_WIDTH:0] clip(input logic signed [SW-1:0] v);
      if (v > SAT_HI) begin
         clip = {1'b1, SAT_HI[COORD_WIDTH-1:0]};
      end else if (v < SAT_LO) begin
         clip = {1'b1, SAT_LO[COORD_WIDTH-1:0]};
      end else begin
         clip = {1'b0, v[COORD_WIDTH-1:0]};
      end
   endfunction

   // Multiply stage.
   erc_pkg::plane_type            plane;
   logic [erc_pkg::PORT_WIDTH-1:0] trig;
   logic signed [TW-1:0]          cos_v, sin_v;
   logic signed [COORD_WIDTH-1:0] op_a, op_b;
   logic signed [PW-1:0]          p_ac_in, p_bs_in, p_as_in, p_bc_in;
   logic signed [PW-1:0]          p_ac_ff, p_bs_ff, p_as_ff, p_bc_ff;
   erc_pkg::ctl_type              mul_ctl_ff;
   erc_pkg::plane_type            mul_plane_ff;
   logic signed [COORD_WIDTH-1:0] mul_point_ff [3];

   always_comb begin
      plane   = src_ctl.inverse ? inv_plane : fwd_plane;
      trig    = src_ctl.inverse ? inv_trig : fwd_trig;
      cos_v   = signed'(trig[2*TW-1:TW]);
      sin_v   = signed'(trig[TW-1:0]);
      op_a    = src_point[plane.a];
      op_b    = src_point[plane.b];
      p_ac_in = PW'(op_a) * PW'(cos_v);
      p_bs_in = PW'(op_b) * PW'(sin_v);
      p_as_in = PW'(op_a) * PW'(sin_v);
      p_bc_in = PW'(op_b) * PW'(cos_v);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ctl_ff <= '0;
      end else begin
         mul_ctl_ff <= src_ctl;
      end
   end

   always_ff @(posedge clock) begin
      mul_plane_ff <= plane;
      p_ac_ff      <= p_ac_in;
      p_bs_ff      <= p_bs_in;
      p_as_ff      <= p_as_in;
      p_bc_ff      <= p_bc_in;
      for (int i = 0; i < 3; i++) begin
         mul_point_ff[i] <= src_point[i];
      end
   end

   // Combine stage. Each product is floored on its own before the add.
   logic signed [SW-1:0]          t_ac, t_bs, t_as, t_bc, sum_a, sum_b;
   logic [COORD_WIDTH:0]          clip_a, clip_b;
   erc_pkg::ctl_type              out_ctl_ff, out_ctl_in;
   logic signed [COORD_WIDTH-1:0] out_point_ff [3];
   logic signed [COORD_WIDTH-1:0] out_point_in [3];

   always_comb begin
      t_ac   = SW'(p_ac_ff) >>> TRIG_FRAC;
      t_bs   = SW'(p_bs_ff) >>> TRIG_FRAC;
      t_as   = SW'(p_as_ff) >>> TRIG_FRAC;
      t_bc   = SW'(p_bc_ff) >>> TRIG_FRAC;
      sum_a  = t_ac - t_bs;
      sum_b  = t_as + t_bc;
      clip_a = clip(sum_a);
      clip_b = clip(sum_b);
      out_ctl_in         = mul_ctl_ff;
      out_ctl_in.clipped = mul_ctl_ff.clipped | clip_a[COORD_WIDTH] | clip_b[COORD_WIDTH];
      for (int i = 0; i < 3; i++) begin
         if (2'(i) == mul_plane_ff.a) begin
            out_point_in[i] = clip_a[COORD_WIDTH-1:0];
         end else if (2'(i) == mul_plane_ff.b) begin
            out_point_in[i] = clip_b[COORD_WIDTH-1:0];
         end else begin
            out_point_in[i] = mul_point_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ctl_ff <= '0;
      end else begin
         out_ctl_ff <= out_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         out_point_ff[i] <= out_point_in[i];
      end
   end

   assign dst_ctl = out_ctl_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dst_point[i] = out_point_ff[i];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/euler_rigid_transform.sv =====
// Top level of the Euler rigid transform: register file, input stage and the pipeline.
// Depends on erc_pkg, erc_xlate and erc_rot.
//
//   channel  ports                                      direction  beat taken when
//   request  start, busy, req_payload                   in         start && !busy
//   result   rsp_valid, rsp_payload                     out        rsp_valid (one cycle)
//   config   csr_valid, csr_ready, csr_index, csr_data  in         csr_valid && csr_ready
//
// One point enters per clock; each request beat passes every stage before its result beat.
// The nine stages are the input register, inverse translation, two stages for each
// of the three plane rotations (products, then add and clip) and forward translation.
// Synchronous reset clears the pipeline valid bits and restores the registers.
// The pipeline never stalls: busy stays low.
`default_nettype none

module euler_rigid_transform #(
   parameter int COORD_WIDTH = erc_pkg::COORD_WIDTH_DEF,
   parameter int TRIG_FRAC   = erc_pkg::TRIG_FRAC_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire erc_pkg::req_type                      req_payload,
   output logic                                       rsp_valid,
   output erc_pkg::rsp_type                           rsp_payload,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [erc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [erc_pkg::PORT_WIDTH-1:0]        csr_data
);

   localparam int PW = erc_pkg::PORT_WIDTH;
   localparam int BW = ((COORD_WIDTH > PW) ? COORD_WIDTH : PW) + 1;
   localparam logic signed [BW-1:0] SAT_HI = BW'({1'b0, {(COORD_WIDTH-1){1'b1}}});
   localparam logic signed [BW-1:0] SAT_LO = -SAT_HI - BW'(1);

   localparam erc_pkg::plane_type ROLL_FWD  = '{a: erc_pkg::AXIS_X, b: erc_pkg::AXIS_Y};
   localparam erc_pkg::plane_type PITCH_FWD = '{a: erc_pkg::AXIS_Z, b: erc_pkg::AXIS_Y};
   localparam erc_pkg::plane_type YAW_FWD   = '{a: erc_pkg::AXIS_Z, b: erc_pkg::AXIS_X};
   localparam erc_pkg::plane_type YAW_INV   = '{a: erc_pkg::AXIS_X, b: erc_pkg::AXIS_Z};
   localparam erc_pkg::plane_type PITCH_INV = '{a: erc_pkg::AXIS_Y, b: erc_pkg::AXIS_Z};
   localparam erc_pkg::plane_type ROLL_INV  = '{a: erc_pkg::AXIS_Y, b: erc_pkg::AXIS_X};

   function automatic logic [COORD_WIDTH:0] clip(input logic signed [BW-1:0] v);
      if (v > SAT_HI) begin
         clip = {1'b1, SAT_HI[COORD_WIDTH-1:0]};
      end else if (v < SAT_LO) begin
         clip = {1'b1, SAT_LO[COORD_WIDTH-1:0]};
      end else begin
         clip = {1'b0, v[COORD_WIDTH-1:0]};
      end
   endfunction

   // Register file. Writes beyond the last register are dropped.
   logic [PW-1:0] shift_x_ff, shift_y_ff, shift_z_ff;
   logic [PW-1:0] yaw_ff, pitch_ff, roll_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_x_ff <= erc_pkg::SHIFT_RESET;
         shift_y_ff <= erc_pkg::SHIFT_RESET;
         shift_z_ff <= erc_pkg::SHIFT_RESET;
         yaw_ff     <= erc_pkg::TRIG_RESET;
         pitch_ff   <= erc_pkg::TRIG_RESET;
         roll_ff    <= erc_pkg::TRIG_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            erc_pkg::REG_SHIFT_X: shift_x_ff <= csr_data;
            erc_pkg::REG_SHIFT_Y: shift_y_ff <= csr_data;
            erc_pkg::REG_SHIFT_Z: shift_z_ff <= csr_data;
            erc_pkg::REG_YAW:     yaw_ff     <= csr_data;
            erc_pkg::REG_PITCH:   pitch_ff   <= csr_data;
            erc_pkg::REG_ROLL:    roll_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   logic signed [PW-1:0] shift_vec [3];

   always_comb begin
      shift_vec[0] = signed'(shift_x_ff);
      shift_vec[1] = signed'(shift_y_ff);
      shift_vec[2] = signed'(shift_z_ff);
   end

   // Input stage: clip the port coordinates to the internal width.
   erc_pkg::ctl_type              in_ctl_ff, in_ctl_in;
   logic signed [COORD_WIDTH-1:0] in_point_ff [3];
   logic signed [COORD_WIDTH-1:0] in_point_in [3];
   logic signed [PW-1:0]          raw [3];
   logic [COORD_WIDTH:0]          raw_clip [3];

   always_comb begin
      raw[0] = req_payload.point_x;
      raw[1] = req_payload.point_y;
      raw[2] = req_payload.point_z;
      in_ctl_in.valid   = start && !busy;
      in_ctl_in.inverse = req_payload.func;
      in_ctl_in.clipped = 1'b0;
      for (int i = 0; i < 3; i++) begin
         raw_clip[i]       = clip(BW'(raw[i]));
         in_point_in[i]    = raw_clip[i][COORD_WIDTH-1:0];
         in_ctl_in.clipped = in_ctl_in.clipped | raw_clip[i][COORD_WIDTH];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ctl_ff <= '0;
      end else begin
         in_ctl_ff <= in_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         in_point_ff[i] <= in_point_in[i];
      end
   end

   erc_pkg::ctl_type              sub_ctl, rot1_ctl, rot2_ctl, rot3_ctl, add_ctl;
   logic signed [COORD_WIDTH-1:0] sub_point [3];
   logic signed [COORD_WIDTH-1:0] rot1_point [3];
   logic signed [COORD_WIDTH-1:0] rot2_point [3];
   logic signed [COORD_WIDTH-1:0] rot3_point [3];
   logic signed [COORD_WIDTH-1:0] add_point [3];

   erc_xlate #(.COORD_WIDTH(COORD_WIDTH)) u_sub (
      .clock     (clock),
      .reset     (reset),
      .on_inverse(1'b1),
      .src_ctl   (in_ctl_ff),
      .src_point (in_point_ff),
      .shift     (shift_vec),
      .dst_ctl   (sub_ctl),
      .dst_point (sub_point)
   );

   erc_rot #(.COORD_WIDTH(COORD_WIDTH), .TRIG_FRAC(TRIG_FRAC)) u_rot1 (
      .clock    (clock),
      .reset    (reset),
      .fwd_plane(ROLL_FWD),
      .inv_plane(YAW_INV),
      .fwd_trig (roll_ff),
      .inv_trig (yaw_ff),
      .src_ctl  (sub_ctl),
      .src_point(sub_point),
      .dst_ctl  (rot1_ctl),
      .dst_point(rot1_point)
   );

   erc_rot #(.COORD_WIDTH(COORD_WIDTH), .TRIG_FRAC(TRIG_FRAC)) u_rot2 (
      .clock    (clock),
      .reset    (reset),
      .fwd_plane(PITCH_FWD),
      .inv_plane(PITCH_INV),
      .fwd_trig (pitch_ff),
      .inv_trig (pitch_ff),
      .src_ctl  (rot1_ctl),
      .src_point(rot1_point),
      .dst_ctl  (rot2_ctl),
      .dst_point(rot2_point)
   );

   erc_rot #(.COORD_WIDTH(COORD_WIDTH), .TRIG_FRAC(TRIG_FRAC)) u_rot3 (
      .clock    (clock),
      .reset    (reset),
      .fwd_plane(YAW_FWD),
      .inv_plane(ROLL_INV),
      .fwd_trig (yaw_ff),
      .inv_trig (roll_ff),
      .src_ctl  (rot2_ctl),
      .src_point(rot2_point),
      .dst_ctl  (rot3_ctl),
      .dst_point(rot3_point)
   );

   erc_xlate #(.COORD_WIDTH(COORD_WIDTH)) u_add (
      .clock     (clock),
      .reset     (reset),
      .on_inverse(1'b0),
      .src_ctl   (rot3_ctl),
      .src_point (rot3_point),
      .shift     (shift_vec),
      .dst_ctl   (add_ctl),
      .dst_point (add_point)
   );

   // Narrower internal widths sign-extend to the ports, wider ones keep the low bits.
   always_comb begin
      rsp_valid             = add_ctl.valid;
      rsp_payload.result_x  = PW'(add_point[0]);
      rsp_payload.result_y  = PW'(add_point[1]);
      rsp_payload.result_z  = PW'(add_point[2]);
      rsp_payload.saturated = add_ctl.clipped;
   end

endmodule

`default_nettype wire

// ===== rtl/core/erc_checker.sv =====
// Port-level checks of the Euler rigid transform and the bind that attaches them.
// Depends on erc_pkg and the top level euler_rigid_transform.
`default_nettype none

module erc_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_valid,
   input wire logic csr_ready
);

   // Every accepted beat comes out after the fixed pipeline depth.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(erc_pkg::LATENCY) rsp_valid)
      else $error("accepted beat did not produce a result at the pipeline depth");

   // No result appears without a beat accepted that many cycles before.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, erc_pkg::LATENCY))
      else $error("result beat without a matching request beat");

   // Reset empties the pipeline.
   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // The block takes a beat and a register write in every cycle.
   a_always_ready: assert property (@(posedge clock) disable iff (reset)
      !busy && csr_ready)
      else $error("block refused a beat");

endmodule

bind euler_rigid_transform erc_checker u_checker (.*);

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench for euler_rigid_transform: directed corner points, then random
// point streams under several register settings, checked against an in-bench predictor.
// Depends on erc_pkg and the euler_rigid_transform RTL only.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import erc_pkg::*;

   localparam int CYCLE_LIMIT = 60000;
   localparam int REPORT_LIMIT = 10;
   localparam logic FUNC_FORWARD = 1'b0;
   localparam logic FUNC_INVERSE = 1'b1;
   localparam logic [CSR_INDEX_WIDTH-1:0] SPARE_INDEX_LOW = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] SPARE_INDEX_HIGH = 3'd7;
   localparam logic signed [PORT_WIDTH-1:0] COORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [PORT_WIDTH-1:0] COORD_MIN = 32'sh8000_0000;
   localparam logic [TRIG_WIDTH-1:0] TRIG_ONE = 16'h4000;
   localparam logic [TRIG_WIDTH-1:0] TRIG_ZERO = 16'h0000;
   localparam logic [TRIG_WIDTH-1:0] TRIG_POS_MAX = 16'h7FFF;
   localparam logic [TRIG_WIDTH-1:0] TRIG_NEG_MAX = 16'h8000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_payload = '0;
   logic rsp_valid;
   rsp_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [PORT_WIDTH-1:0] csr_data = '0;

   logic [PORT_WIDTH-1:0] transform_regs [0:5];
   rsp_type expected_points [$];
   int fault_count = 0;
   int cycle_count = 0;

   euler_rigid_transform dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_payload(rsp_payload),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   function automatic longint trig_product(input longint coord, input longint trig);
      return (coord * trig) >>> TRIG_FRAC_DEF;
   endfunction

   function automatic longint clip_coord(input longint value, inout bit clipped);
      if (value > longint'(COORD_MAX)) begin
         clipped = 1'b1;
         return longint'(COORD_MAX);
      end
      if (value < longint'(COORD_MIN)) begin
         clipped = 1'b1;
         return longint'(COORD_MIN);
      end
      return value;
   endfunction

   // Rotates the pair (a, b): a' = a*c - b*s, b' = a*s + b*c, each product shifted alone.
   function automatic void rotate_pair(inout longint a, inout longint b,
                                       input longint c, input longint s, inout bit clipped);
      longint next_a;
      longint next_b;
      next_a = clip_coord(trig_product(a, c) - trig_product(b, s), clipped);
      next_b = clip_coord(trig_product(a, s) + trig_product(b, c), clipped);
      a = next_a;
      b = next_b;
   endfunction

   function automatic rsp_type transform_point(input req_type item);
      longint x, y, z, tx, ty, tz;
      longint yaw_c, yaw_s, pitch_c, pitch_s, roll_c, roll_s;
      bit clipped;
      rsp_type outcome;
      clipped = 1'b0;
      x = longint'(item.point_x);
      y = longint'(item.point_y);
      z = longint'(item.point_z);
      tx = longint'($signed(transform_regs[REG_SHIFT_X]));
      ty = longint'($signed(transform_regs[REG_SHIFT_Y]));
      tz = longint'($signed(transform_regs[REG_SHIFT_Z]));
      yaw_c = longint'($signed(transform_regs[REG_YAW][31:16]));
      yaw_s = longint'($signed(transform_regs[REG_YAW][15:0]));
      pitch_c = longint'($signed(transform_regs[REG_PITCH][31:16]));
      pitch_s = longint'($signed(transform_regs[REG_PITCH][15:0]));
      roll_c = longint'($signed(transform_regs[REG_ROLL][31:16]));
      roll_s = longint'($signed(transform_regs[REG_ROLL][15:0]));
      if (item.func == FUNC_FORWARD) begin
         rotate_pair(x, y, roll_c, roll_s, clipped);
         rotate_pair(z, y, pitch_c, pitch_s, clipped);
         rotate_pair(z, x, yaw_c, yaw_s, clipped);
         x = clip_coord(x + tx, clipped);
         y = clip_coord(y + ty, clipped);
         z = clip_coord(z + tz, clipped);
      end else begin
         x = clip_coord(x - tx, clipped);
         y = clip_coord(y - ty, clipped);
         z = clip_coord(z - tz, clipped);
         rotate_pair(x, z, yaw_c, yaw_s, clipped);
         rotate_pair(y, z, pitch_c, pitch_s, clipped);
         rotate_pair(y, x, roll_c, roll_s, clipped);
      end
      outcome.result_x = x[31:0];
      outcome.result_y = y[31:0];
      outcome.result_z = z[31:0];
      outcome.saturated = clipped;
      return outcome;
   endfunction

   // ---------------------------------------------------------------- result checking

   task automatic note_fault(input string what, input logic [31:0] want,
                             input logic [31:0] got);
      fault_count++;
      if (fault_count <= REPORT_LIMIT)
         $display("mismatch in %s: expected %h, got %h", what, want, got);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid !== 1'b0) begin
         if (expected_points.size() == 0) begin
            note_fault("unexpected result beat", '0, rsp_payload.result_x);
         end else begin
            want = expected_points.pop_front();
            if (rsp_payload.result_x !== want.result_x)
               note_fault("result_x", want.result_x, rsp_payload.result_x);
            if (rsp_payload.result_y !== want.result_y)
               note_fault("result_y", want.result_y, rsp_payload.result_y);
            if (rsp_payload.result_z !== want.result_z)
               note_fault("result_z", want.result_z, rsp_payload.result_z);
            if (rsp_payload.saturated !== want.saturated)
               note_fault("saturated", {31'b0, want.saturated},
                          {31'b0, rsp_payload.saturated});
         end
      end
   end

   // ---------------------------------------------------------------- drivers

   // Leaves start high so that the next point can follow in the very next cycle.
   // Each cycle slot is left idle with the given chance before the beat is driven.
   task automatic send_point(input req_type item, input int idle_pct);
      int gap;
      gap = 0;
      while ($urandom_range(1, 100) <= idle_pct)
         gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (busy !== 1'b0);
      expected_points.insert(expected_points.size(), transform_point(item));
   endtask

   task automatic send_xyz(input logic func, input logic [31:0] x, input logic [31:0] y,
                           input logic [31:0] z);
      req_type item;
      item.func = func;
      item.point_x = x;
      item.point_y = y;
      item.point_z = z;
      send_point(item, 0);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   // Keeps csr_valid high; the caller lowers it after the last write of a burst.
   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                 input logic [PORT_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (index <= REG_ROLL)
         transform_regs[index] = value;
   endtask

   task automatic program_transform(input logic [31:0] sx, input logic [31:0] sy,
                                    input logic [31:0] sz, input logic [31:0] yaw,
                                    input logic [31:0] pitch, input logic [31:0] roll);
      wait_idle();
      write_register(REG_SHIFT_X, sx);
      write_register(REG_SHIFT_Y, sy);
      write_register(REG_SHIFT_Z, sz);
      write_register(REG_YAW, yaw);
      write_register(REG_PITCH, pitch);
      write_register(REG_ROLL, roll);
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------- random values

   function automatic logic [31:0] random_coord();
      case ($urandom_range(0, 9))
         0: return COORD_MAX;
         1: return COORD_MIN;
         2, 3, 4: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] random_shift();
      case ($urandom_range(0, 7))
         0: return COORD_MAX;
         1: return COORD_MIN;
         2, 3, 4, 5: return 32'($signed($urandom_range(0, 8388608)) - 4194304);
         default: return $urandom();
      endcase
   endfunction

   // Mostly values within the unit range, so that rotations rarely clip.
   function automatic logic [31:0] random_trig();
      logic [15:0] c;
      logic [15:0] s;
      if ($urandom_range(0, 3) == 0)
         return $urandom();
      c = 16'($signed($urandom_range(0, 32768)) - 16384);
      s = 16'($signed($urandom_range(0, 32768)) - 16384);
      return {c, s};
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_identity_extremes();
      send_xyz(FUNC_FORWARD, '0, '0, '0);
      send_xyz(FUNC_FORWARD, COORD_MAX, COORD_MIN, 32'hFFFF_FFFF);
      send_xyz(FUNC_FORWARD, COORD_MIN, COORD_MAX, 32'h0000_0001);
      send_xyz(FUNC_FORWARD, 32'h0001_0000, 32'hFFFF_0000, COORD_MAX);
      send_xyz(FUNC_INVERSE, '0, '0, '0);
      send_xyz(FUNC_INVERSE, COORD_MAX, COORD_MIN, 32'hFFFF_FFFF);
      send_xyz(FUNC_INVERSE, COORD_MIN, COORD_MAX, 32'h0000_0001);
      send_xyz(FUNC_INVERSE, 32'hFFFF_0000, 32'h0001_0000, COORD_MIN);
   endtask

   task automatic test_translation_overflow();
      program_transform(COORD_MAX, COORD_MAX, COORD_MIN,
                        {TRIG_ONE, TRIG_ZERO}, {TRIG_ONE, TRIG_ZERO}, {TRIG_ONE, TRIG_ZERO});
      send_xyz(FUNC_FORWARD, COORD_MAX, 32'h0000_0001, COORD_MIN);
      send_xyz(FUNC_INVERSE, COORD_MIN, COORD_MIN, COORD_MAX);
      send_xyz(FUNC_FORWARD, '0, '0, '0);
      program_transform(COORD_MIN, COORD_MIN, COORD_MAX,
                        {TRIG_ONE, TRIG_ZERO}, {TRIG_ONE, TRIG_ZERO}, {TRIG_ONE, TRIG_ZERO});
      send_xyz(FUNC_FORWARD, COORD_MIN, COORD_MIN, COORD_MAX);
      send_xyz(FUNC_INVERSE, COORD_MAX, COORD_MAX, COORD_MIN);
      send_xyz(FUNC_INVERSE, '0, '0, '0);
   endtask

   // Trig values far outside the unit circle make the rotations themselves clip.
   task automatic test_raw_trig();
      program_transform('0, '0, '0, {TRIG_POS_MAX, TRIG_POS_MAX},
                        {TRIG_NEG_MAX, TRIG_NEG_MAX}, {TRIG_NEG_MAX, TRIG_POS_MAX});
      send_xyz(FUNC_FORWARD, COORD_MAX, COORD_MIN, COORD_MAX);
      send_xyz(FUNC_INVERSE, COORD_MIN, COORD_MAX, COORD_MIN);
      send_xyz(FUNC_FORWARD, 32'h0000_4000, 32'hFFFF_C000, 32'h0000_0003);
      program_transform(32'h0001_0000, 32'hFFFE_0000, 32'h0003_0000,
                        {TRIG_ZERO, TRIG_ZERO}, {TRIG_ZERO, TRIG_ZERO}, {TRIG_ZERO, TRIG_ZERO});
      send_xyz(FUNC_FORWARD, COORD_MAX, COORD_MIN, 32'h1234_5678);
      send_xyz(FUNC_INVERSE, COORD_MIN, COORD_MAX, 32'h8765_4321);
   endtask

   // Writes to indexes past the last register must leave every register alone.
   task automatic test_ignored_index();
      wait_idle();
      write_register(SPARE_INDEX_LOW, $urandom());
      write_register(SPARE_INDEX_HIGH, $urandom());
      csr_valid <= 1'b0;
      send_xyz(FUNC_FORWARD, random_coord(), random_coord(), random_coord());
      send_xyz(FUNC_INVERSE, random_coord(), random_coord(), random_coord());
   endtask

   task automatic test_random_stream(input int count, input int idle_pct);
      req_type item;
      program_transform(random_shift(), random_shift(), random_shift(),
                        random_trig(), random_trig(), random_trig());
      for (int i = 0; i < count; i++) begin
         item.func = 1'($urandom_range(0, 1));
         item.point_x = random_coord();
         item.point_y = random_coord();
         item.point_z = random_coord();
         send_point(item, idle_pct);
      end
   endtask

   initial begin
      transform_regs[REG_SHIFT_X] = SHIFT_RESET;
      transform_regs[REG_SHIFT_Y] = SHIFT_RESET;
      transform_regs[REG_SHIFT_Z] = SHIFT_RESET;
      transform_regs[REG_YAW] = TRIG_RESET;
      transform_regs[REG_PITCH] = TRIG_RESET;
      transform_regs[REG_ROLL] = TRIG_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_identity_extremes();
      test_translation_overflow();
      test_raw_trig();
      test_ignored_index();
      test_random_stream(120, 0);
      test_random_stream(120, 56);
      test_random_stream(120, 30);
      test_random_stream(120, 0);
      test_random_stream(120, 56);

      wait_idle();
      repeat (2 * LATENCY) @(posedge clock);
      if (fault_count == 0 && expected_points.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/erc_pkg.sv
rtl/core/erc_xlate.sv
rtl/core/erc_rot.sv
rtl/core/euler_rigid_transform.sv
rtl/core/erc_checker.sv
bench/testbench.sv
